@@ src/swdr_pkg.sv @@
package swdr_pkg;

  localparam int PERIOD_W   = 6;
  localparam int SPEED_W    = 7;
  localparam int COIL_W     = 4;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 7;

  // full scale of the speed register
  localparam int unsigned SPEED_FULL = 100;
  // x / 100 == (x * 5243) >> 19 for every x below 40000
  localparam int unsigned RECIP       = 5243;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_PERCENT  = 4'd0,
    CFG_ROTATE_FORWARD = 4'd1
  } cfg_reg_t;

  typedef logic [COIL_W-1:0] coil_t;

  // one-hot wave drive order, forward direction
  localparam coil_t WAVE_TABLE [4] = '{4'h1, 4'h2, 4'h4, 4'h8};

  typedef struct packed {
    logic [PERIOD_W-1:0] target_period;
    logic                rotate_forward;
  } drive_cfg_t;

  typedef struct packed {
    coil_t coil_pattern;
    logic  step_taken;
  } step_res_t;

endpackage

@@ src/swdr_tick_if.sv @@
interface swdr_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

@@ src/swdr_res_if.sv @@
interface swdr_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] coil_pattern;
  logic       step_taken;

  modport source (output valid, output coil_pattern, output step_taken, input ready);
  modport sink   (input valid, input coil_pattern, input step_taken, output ready);
endinterface

@@ src/swdr_cfg_if.sv @@
interface swdr_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] index;
  logic [6:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/swdr_target.sv @@
module swdr_target
  import swdr_pkg::*;
#(
  parameter int MIN_PERIOD_MS = 2,
  parameter int MAX_PERIOD_MS = 50
) (
  input  logic       clk,
  input  logic       rst,
  swdr_cfg_if.sink   cfg_ch,
  output drive_cfg_t drive_cfg
);

  localparam int unsigned SPAN   = MAX_PERIOD_MS - MIN_PERIOD_MS;
  localparam int unsigned K      = SPAN * RECIP;
  localparam int          PROD_W = SPEED_W + RECIP_SHIFT;
  localparam logic [PERIOD_W-1:0] MAX_P = PERIOD_W'(MAX_PERIOD_MS);
  localparam logic [SPEED_W-1:0]  FULL  = SPEED_W'(SPEED_FULL);

  logic [SPEED_W-1:0]  speed_sat;
  logic [PROD_W-1:0]   prod;
  logic [PERIOD_W-1:0] target_next;
  logic [PERIOD_W-1:0] target_period;
  logic                rotate_forward;

  assign cfg_ch.ready = 1'b1;

  // saturate, then scale by span/100 with a constant reciprocal
  assign speed_sat   = (cfg_ch.data > FULL) ? FULL : cfg_ch.data;
  assign prod        = PROD_W'(speed_sat) * PROD_W'(K);
  assign target_next = MAX_P - PERIOD_W'(prod >> RECIP_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_period  <= MAX_P;
      rotate_forward <= 1'b1;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == CFG_SPEED_PERCENT) begin
        target_period <= target_next;
      end else if (cfg_ch.index == CFG_ROTATE_FORWARD) begin
        rotate_forward <= cfg_ch.data[0];
      end
    end
  end

  assign drive_cfg.target_period  = target_period;
  assign drive_cfg.rotate_forward = rotate_forward;

  a_target_range: assert property (@(posedge clk) disable iff (rst)
    target_period >= PERIOD_W'(MIN_PERIOD_MS) && target_period <= MAX_P)
    else $error("target period outside min..max");

endmodule

@@ src/swdr_step.sv @@
module swdr_step
  import swdr_pkg::*;
#(
  parameter int MIN_PERIOD_MS = 2,
  parameter int MAX_PERIOD_MS = 50
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       tick,
  input  drive_cfg_t drive_cfg,
  output step_res_t  step_res
);

  localparam logic [PERIOD_W-1:0] MIN_P = PERIOD_W'(MIN_PERIOD_MS);
  localparam logic [PERIOD_W-1:0] MAX_P = PERIOD_W'(MAX_PERIOD_MS);

  logic [PERIOD_W-1:0] current_period;
  logic [PERIOD_W-1:0] ticks_remaining;
  logic [PHASE_W-1:0]  phase_index;
  coil_t               coil_output;

  logic                due;
  logic [PERIOD_W-1:0] period_next;
  logic [PERIOD_W-1:0] wait_len;
  logic [PHASE_W-1:0]  phase_sel;
  coil_t               coil_next;

  assign due = tick && (ticks_remaining == '0);

  // one ms toward the target at each step
  always_comb begin
    if (current_period < drive_cfg.target_period) begin
      period_next = current_period + 1'b1;
    end else if (current_period > drive_cfg.target_period) begin
      period_next = current_period - 1'b1;
    end else begin
      period_next = current_period;
    end
  end

  // reverse order is 3 - phase, which is the bitwise complement
  assign phase_sel = drive_cfg.rotate_forward ? phase_index : ~phase_index;
  assign coil_next = WAVE_TABLE[phase_sel];
  assign wait_len  = (period_next < MIN_P) ? MIN_P : period_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_period  <= MAX_P;
      ticks_remaining <= '0;
      phase_index     <= '0;
      coil_output     <= '0;
    end else if (accept && tick) begin
      if (due) begin
        current_period  <= period_next;
        coil_output     <= coil_next;
        phase_index     <= phase_index + 1'b1;
        ticks_remaining <= wait_len - 1'b1;
      end else begin
        ticks_remaining <= ticks_remaining - 1'b1;
      end
    end
  end

  assign step_res.coil_pattern = due ? coil_next : coil_output;
  assign step_res.step_taken   = due;

  a_step_onehot: assert property (@(posedge clk) disable iff (rst)
    step_res.step_taken |-> $onehot(step_res.coil_pattern))
    else $error("step pattern not one-hot");

  a_countdown: assert property (@(posedge clk) disable iff (rst)
    accept && tick && !due |=> ticks_remaining == $past(ticks_remaining) - 1'b1)
    else $error("wait countdown slipped");

  a_period_floor: assert property (@(posedge clk) disable iff (rst)
    current_period >= MIN_P)
    else $error("period below minimum");

endmodule

@@ src/stepper_wave_drive_ramp.sv @@
// result: the result item of an accepted tick item is registered and offered in the next cycle
// throughput: one item per cycle while the result side is ready; the step counter and ramp update in a single pass
// the result register frees itself in the cycle it is taken, so input stays ready
// reset (rst, synchronous): coils off, period at max, first tick steps,
// speed 0 and forward direction
module stepper_wave_drive_ramp
  import swdr_pkg::*;
#(
  parameter int MIN_PERIOD_MS = 2,
  parameter int MAX_PERIOD_MS = 50
) (
  input  logic        clk,
  input  logic        rst,
  swdr_tick_if.sink   tick_ch,
  swdr_res_if.source  res_ch,
  swdr_cfg_if.sink    cfg_ch
);

  // register file and target period, worked out when speed is written
  drive_cfg_t drive_cfg;
  // combinational result of the item at the input
  step_res_t  step_res;
  // result register
  step_res_t  res_q;
  logic       res_valid;
  logic       accept;

  // a waiting result does not block the input if it leaves this cycle
  assign tick_ch.ready = !res_valid || res_ch.ready;
  assign accept        = tick_ch.valid && tick_ch.ready;

  swdr_target #(
    .MIN_PERIOD_MS (MIN_PERIOD_MS),
    .MAX_PERIOD_MS (MAX_PERIOD_MS)
  ) u_target (
    .clk       (clk),
    .rst       (rst),
    .cfg_ch    (cfg_ch),
    .drive_cfg (drive_cfg)
  );

  // countdown, ramp, phase and coil state
  swdr_step #(
    .MIN_PERIOD_MS (MIN_PERIOD_MS),
    .MAX_PERIOD_MS (MAX_PERIOD_MS)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .tick      (tick_ch.tick),
    .drive_cfg (drive_cfg),
    .step_res  (step_res)
  );

  // output stage: valid cleared by reset, payload loaded on accept only
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= step_res;
    end
  end

  assign res_ch.valid        = res_valid;
  assign res_ch.coil_pattern = res_q.coil_pattern;
  assign res_ch.step_taken   = res_q.step_taken;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid && res_q == $past(step_res))
    else $error("accepted item has no result");

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  import swdr_pkg::*;

  // block configuration under test, kept at the design defaults
  localparam int MIN_MS = 2;
  localparam int MAX_MS = 50;

  // cycles the result side is held off to back the block up
  localparam int HOLD_CYCLES = 40;
  // cycles with no item moving on any channel before the run is abandoned
  localparam int IDLE_LIMIT  = 1000;
  // a register index that decodes to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'd15;

  logic clk;
  logic rst;

  swdr_tick_if tick_ch ();
  swdr_res_if  res_ch ();
  swdr_cfg_if  cfg_ch ();

  stepper_wave_drive_ramp #(
    .MIN_PERIOD_MS (MIN_MS),
    .MAX_PERIOD_MS (MAX_MS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .tick_ch(tick_ch),
    .res_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  // ---------------------------------------------------------------------
  // shadow of the drive state and its registers
  // ---------------------------------------------------------------------
  logic [SPEED_W-1:0]  set_speed   = '0;
  logic                set_forward = 1'b1;
  logic [PERIOD_W-1:0] cur_period  = PERIOD_W'(MAX_MS);
  logic [PERIOD_W-1:0] ticks_left  = '0;
  logic [PHASE_W-1:0]  phase_idx   = '0;
  coil_t               coil_now    = '0;

  logic      tick_pending [$];   // tick items waiting to be offered
  step_res_t coil_expect  [$];   // predicted result items, oldest first

  int n_ticks_put = 0;           // tick items placed on the channel
  int n_ticks_acc = 0;           // tick items taken by the block
  int n_errors    = 0;

  // idling control shared by the sender and the receiver
  logic calm        = 1'b0;      // no random gaps while set
  int   holds_asked = 0;
  int   holds_given = 0;

  // one tick item through the stepper: ramp, next pattern, new wait
  function automatic step_res_t drive_advance(logic tick_in);
    step_res_t res;
    int        spd;
    int        tgt;
    int        wait_ms;
    res.step_taken = 1'b0;
    if (tick_in) begin
      if (ticks_left != 0) begin
        ticks_left = ticks_left - 1'b1;
      end else begin
        // speeds above full scale saturate
        spd = (set_speed > SPEED_FULL) ? SPEED_FULL : int'(set_speed);
        tgt = MAX_MS - (spd * (MAX_MS - MIN_MS)) / SPEED_FULL;
        // period walks one ms towards the target per step
        if (cur_period < tgt) begin
          cur_period = cur_period + 1'b1;
        end else if (cur_period > tgt) begin
          cur_period = cur_period - 1'b1;
        end
        // reverse order is the forward table read backwards
        coil_now  = set_forward ? WAVE_TABLE[phase_idx] : WAVE_TABLE[~phase_idx];
        phase_idx = phase_idx + 1'b1;
        wait_ms   = (cur_period < MIN_MS) ? MIN_MS : int'(cur_period);
        if (wait_ms == 0) begin
          wait_ms = 1;
        end
        ticks_left     = PERIOD_W'(wait_ms - 1);
        res.step_taken = 1'b1;
      end
    end
    res.coil_pattern = coil_now;
    return res;
  endfunction

  task automatic flag_mismatch(string what);
    $display("%0t mismatch: %s", $time, what);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------
  initial begin : clock_gen
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // tick sender: changes on the falling edge, holds an item until taken
  // ---------------------------------------------------------------------
  int send_gap = 0;

  always @(negedge clk) begin : tick_driver
    logic nxt_valid;
    logic nxt_tick;
    nxt_valid = tick_ch.valid;
    nxt_tick  = tick_ch.tick;
    if (rst) begin
      nxt_valid = 1'b0;
      nxt_tick  = 1'b0;
    end else if (!tick_ch.valid || n_ticks_acc == n_ticks_put) begin
      // the item on the channel, if any, has gone in
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (!calm && $urandom_range(7) == 0) begin
        // burst of idle cycles of random length, this one included
        send_gap = $urandom_range(5);
      end else if (tick_pending.size() != 0) begin
        nxt_tick  = tick_pending.pop_front();
        nxt_valid = 1'b1;
        n_ticks_put++;
      end
    end
    tick_ch.valid <= nxt_valid;
    tick_ch.tick  <= nxt_tick;
  end

  // ---------------------------------------------------------------------
  // result receiver: random stall bursts plus the long hold-off
  // ---------------------------------------------------------------------
  int sink_gap  = 0;
  int hold_left = 0;

  always @(negedge clk) begin : res_receiver
    logic rdy;
    rdy = 1'b1;
    if (rst) begin
      rdy = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (holds_given < holds_asked) begin
      // long hold so the block fills and stalls its tick input
      holds_given++;
      hold_left = HOLD_CYCLES - 1;
      rdy       = 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      rdy = 1'b0;
    end else if (!calm && $urandom_range(7) == 0) begin
      sink_gap = $urandom_range(5);
      rdy      = 1'b0;
    end
    res_ch.ready <= rdy;
  end

  // ---------------------------------------------------------------------
  // monitor: predicts on every tick taken, checks every result taken
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive_monitor
    step_res_t want;
    if (!rst) begin
      // prediction first, so a same-edge result still finds its entry
      if (tick_ch.valid && tick_ch.ready) begin
        coil_expect.push_back(drive_advance(tick_ch.tick));
        n_ticks_acc++;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (coil_expect.size() == 0) begin
          flag_mismatch($sformatf("result item with nothing expected, coil %h step %b",
                                  res_ch.coil_pattern, res_ch.step_taken));
        end else begin
          want = coil_expect.pop_front();
          if (res_ch.coil_pattern !== want.coil_pattern) begin
            flag_mismatch($sformatf("coil_pattern got %h want %h",
                                    res_ch.coil_pattern, want.coil_pattern));
          end
          if (res_ch.step_taken !== want.step_taken) begin
            flag_mismatch($sformatf("step_taken got %b want %b",
                                    res_ch.step_taken, want.step_taken));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // watchdog: cycles in a row with no item moving anywhere
  // ---------------------------------------------------------------------
  int idle_run = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_run = 0;
    end else begin
      idle_run++;
    end
    if (idle_run >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // register write, only ever issued with the block drained
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_SPEED_PERCENT) begin
      set_speed = val;
    end else if (idx == CFG_ROTATE_FORWARD) begin
      set_forward = val[0];
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // one tick item in zero_odds carries no tick
  task automatic queue_ticks(int n, int zero_odds);
    for (int i = 0; i < n; i++) begin
      tick_pending.push_back($urandom_range(zero_odds - 1) != 0);
    end
  endtask

  // stimulus waits until every queued tick is taken and every predicted result has come back
  task automatic settle();
    while (tick_pending.size() != 0 || n_ticks_acc != n_ticks_put
           || coil_expect.size() != 0) begin
      @(posedge clk);
    end
    // margin on top of the registered result stage
    repeat (3) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic [SPEED_W-1:0] spd;
    int                 n_items;
    int                 zero_odds;

    rst          = 1'b1;
    tick_ch.valid = 1'b0;
    tick_ch.tick  = 1'b0;
    res_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset values, pattern held at zero before the first step,
    // no-tick items, then the first step and the start of its wait
    calm = 1'b1;
    foreach (tick_pending[i]) tick_pending.delete(i);
    tick_pending.push_back(1'b0);
    tick_pending.push_back(1'b0);
    tick_pending.push_back(1'b1);
    tick_pending.push_back(1'b0);
    tick_pending.push_back(1'b1);
    tick_pending.push_back(1'b1);
    settle();

    // an unused index must leave both registers alone
    cfg_write(CFG_IDX_SPARE, 7'h7f);
    tick_pending.push_back(1'b1);
    tick_pending.push_back(1'b0);
    tick_pending.push_back(1'b1);
    settle();

    // speed above full scale, reverse order with spare data bits set
    cfg_write(CFG_SPEED_PERCENT, 7'h7f);
    cfg_write(CFG_ROTATE_FORWARD, 7'h7e);
    tick_pending.push_back(1'b1);
    tick_pending.push_back(1'b1);
    tick_pending.push_back(1'b0);
    tick_pending.push_back(1'b1);
    settle();

    // random phases; the first is the longest and carries the long
    // receiver hold-off, the last runs without any idling
    for (int n_phase = 0; n_phase < 10; n_phase++) begin
      case (n_phase)
        0: spd = 7'd127;
        1: spd = 7'd0;
        2: spd = SPEED_W'(SPEED_FULL);
        3: spd = 7'd101;
        4: spd = 7'd1;
        5: spd = 7'd99;
        default: spd = SPEED_W'($urandom_range(0, 127));
      endcase
      if ($urandom_range(2) == 0) begin
        cfg_write(CFG_SPEED_PERCENT + CFG_IDX_W'($urandom_range(1, 14)),
                  CFG_DATA_W'($urandom_range(0, 127)));
      end
      cfg_write(CFG_SPEED_PERCENT, spd);
      // direction toggles each phase, upper data bits random
      cfg_write(CFG_ROTATE_FORWARD,
                {PHASE_W'(0) | 6'($urandom_range(0, 63)), n_phase[0]});

      calm      = (n_phase == 9) || (n_phase == 5);
      n_items   = (n_phase == 0) ? 180 : $urandom_range(30, 60);
      zero_odds = (n_phase == 0) ? 16 : $urandom_range(2, 8);
      queue_ticks(n_items, zero_odds);
      if (n_phase == 0) begin
        // receiver backs off while ticks keep coming
        holds_asked++;
      end
      settle();
    end

    // nothing left in flight; allow the output register to quieten
    repeat (5) @(posedge clk);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
